// ===== hw/rtl/esi_pkg.sv =====
// Shared types and constants for the e-stop safety interlock.
package esi_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_OVERRIDE   = 3'd0,
    CFG_OC_LIMIT   = 3'd1,
    CFG_OC_TIME    = 3'd2,
    CFG_IDLE_CNT   = 3'd3,
    CFG_RUN_CNT    = 3'd4,
    CFG_HOMING_CNT = 3'd5,
    CFG_LINGER     = 3'd6,
    CFG_SW_CNT     = 3'd7
  } cfg_idx_e;

  localparam int unsigned CfgDataW = 16;

  // Reset values of the configuration registers.
  localparam logic [14:0] OcLimitRst   = 15'd10000;
  localparam logic [15:0] OcTimeRst    = 16'd200;
  localparam logic [7:0]  IdleCntRst   = 8'd8;
  localparam logic [7:0]  RunCntRst    = 8'd75;
  localparam logic [7:0]  HomingCntRst = 8'd225;
  localparam logic [7:0]  LingerRst    = 8'd100;
  localparam logic [7:0]  SwCntRst     = 8'd5;

  // Live configuration.
  typedef struct packed {
    logic        override_en;
    logic [14:0] oc_limit;
    logic [15:0] oc_time;
    logic [7:0]  idle_cnt;
    logic [7:0]  run_cnt;
    logic [7:0]  homing_cnt;
    logic [7:0]  linger;
    logic [7:0]  sw_cnt;
  } cfg_t;

  // A classified tick as it sits in the queue (timestamp travels beside it).
  typedef struct packed {
    logic estop_in;
    logic sel_raw;
    logic rst_raw;
    logic over;
    logic homing;
    logic strict;
    logic joystick;
  } cls_t;

  localparam int unsigned ClsW = $bits(cls_t);

  // One result beat.
  typedef struct packed {
    logic relay_motor;
    logic relay_status;
    logic relay_mode;
    logic estop_active;
    logic select_mode;
    logic reset_active;
    logic emergency;
    logic fault_estop;
    logic overcurrent_fault;
    logic clear_other_faults;
    logic rehome_request;
  } res_t;

endpackage

// ===== hw/rtl/esi_front.sv =====
// Front end: takes input beats and classifies them for the queue.
module esi_front #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          estop_pressed_raw_i,
  input  logic                          select_raw_i,
  input  logic                          reset_raw_i,
  input  logic signed [15:0]            current_ma_i,
  input  logic [31:0]                   now_ms_i,
  input  logic                          motor_homing_i,
  input  logic                          motor_testing_i,
  input  logic                          joystick_mode_i,
  input  logic [14:0]                   oc_limit_i,
  output logic                          push_valid_o,
  input  logic                          push_ready_i,
  output esi_pkg::cls_t                 cls_o,
  output logic [TIME_WIDTH-1:0]         now_o
);
  import esi_pkg::*;

  logic signed [16:0] cur_s;
  logic signed [16:0] lim_s;

  // Accept whenever the queue has room.
  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;

  // Magnitude check against the limit, widened so the negation cannot overflow.
  assign cur_s = {current_ma_i[15], current_ma_i};
  assign lim_s = signed'({2'b00, oc_limit_i});

  always_comb begin
    cls_o.estop_in  = estop_pressed_raw_i;
    cls_o.sel_raw   = select_raw_i;
    cls_o.rst_raw   = reset_raw_i;
    cls_o.over      = (cur_s > lim_s) || (cur_s < -lim_s);
    cls_o.homing    = motor_homing_i;
    cls_o.strict    = motor_homing_i | motor_testing_i;
    cls_o.joystick  = joystick_mode_i;
  end

  // Timestamp taken modulo the timer width.
  assign now_o = TIME_WIDTH'(now_ms_i);

endmodule

// ===== hw/rtl/esi_queue.sv =====
// Two-entry queue between the classifying front end and the back end.
module esi_queue #(
  parameter int unsigned DW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  logic [DW-1:0] push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output logic [DW-1:0] pop_data_o
);
  logic [DW-1:0] mem_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    count_q, count_d;
  logic          push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage, no reset needed.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hw/rtl/esi_back.sv =====
// Back end: debounce, overcurrent timing, emergency latch and relay drive.
module esi_back #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  esi_pkg::cfg_t         cfg_i,
  input  logic                  pop_valid_i,
  output logic                  pop_ready_o,
  input  esi_pkg::cls_t         cls_i,
  input  logic [TIME_WIDTH-1:0] now_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output esi_pkg::res_t         res_o
);
  import esi_pkg::*;

  logic [7:0]            estop_cnt_q, estop_cnt_d;
  logic [7:0]            linger_q, linger_d;
  logic [7:0]            sel_cnt_q, sel_cnt_d;
  logic                  sel_lvl_q, sel_lvl_d;
  logic                  sel_known_q, sel_known_d;
  logic [7:0]            rst_cnt_q, rst_cnt_d;
  logic                  over_timing_q, over_timing_d;
  logic [TIME_WIDTH-1:0] over_start_q, over_start_d;
  logic                  emer_q, emer_d;
  logic                  efault_q, efault_d;
  logic                  ofault_q, ofault_d;
  logic                  motor_q, motor_d;
  logic                  status_q, status_d;
  logic                  mode_q, mode_d;
  logic                  out_valid_q, out_valid_d;
  res_t                  res_q, res_d;

  logic                  pop;
  logic [7:0]            thr;
  logic [7:0]            sel_inc;
  logic                  estop_act;
  logic                  rst_act;
  logic [TIME_WIDTH-1:0] elapsed;
  logic                  rehome;
  logic                  clear_other;

  // The output register frees up when its beat is taken.
  assign pop_ready_o = !out_valid_q || out_ready_i;
  assign pop         = pop_valid_i & pop_ready_o;

  // One tick of the interlock.
  always_comb begin
    estop_cnt_d   = estop_cnt_q;
    sel_cnt_d     = sel_cnt_q;
    sel_lvl_d     = sel_lvl_q;
    sel_known_d   = sel_known_q;
    rst_cnt_d     = rst_cnt_q;
    over_timing_d = over_timing_q;
    over_start_d  = over_start_q;
    emer_d        = emer_q;
    efault_d      = efault_q;
    ofault_d      = ofault_q;
    motor_d       = motor_q;
    status_d      = status_q;
    mode_d        = mode_q;
    rehome        = 1'b0;
    clear_other   = 1'b0;
    sel_inc       = (sel_cnt_q != 8'hFF) ? sel_cnt_q + 8'd1 : sel_cnt_q;

    // Strict window reloads while the motor relay was on last tick.
    if (motor_q) begin
      linger_d = cfg_i.linger;
    end else if (linger_q != 8'd0) begin
      linger_d = linger_q - 8'd1;
    end else begin
      linger_d = 8'd0;
    end
    if (linger_d != 8'd0) begin
      thr = cls_i.strict ? cfg_i.homing_cnt : cfg_i.run_cnt;
    end else begin
      thr = cfg_i.idle_cnt;
    end

    // E-stop debounce.
    if (cls_i.estop_in) begin
      if (estop_cnt_q < thr) begin
        estop_cnt_d = estop_cnt_q + 8'd1;
      end
    end else begin
      estop_cnt_d = 8'd0;
    end
    estop_act = (estop_cnt_d >= thr);

    // Mode switch debounce; the first read after reset is taken as is.
    if (!sel_known_q) begin
      sel_lvl_d   = cls_i.sel_raw;
      sel_known_d = 1'b1;
    end else if (cls_i.sel_raw != sel_lvl_q) begin
      if (sel_inc >= cfg_i.sw_cnt) begin
        sel_lvl_d = cls_i.sel_raw;
        sel_cnt_d = 8'd0;
      end else begin
        sel_cnt_d = sel_inc;
      end
    end else begin
      sel_cnt_d = 8'd0;
    end

    // Reset button debounce.
    if (cls_i.rst_raw) begin
      if (rst_cnt_q < cfg_i.sw_cnt) begin
        rst_cnt_d = rst_cnt_q + 8'd1;
      end
    end else begin
      rst_cnt_d = 8'd0;
    end
    rst_act = (rst_cnt_d >= cfg_i.sw_cnt);

    // Sustained overcurrent trip; the timer starts on the first over tick.
    over_start_d = over_timing_q ? over_start_q : now_i;
    elapsed      = now_i - over_start_d;
    if (!cfg_i.override_en && cls_i.over) begin
      over_timing_d = 1'b1;
      if (elapsed >= TIME_WIDTH'(cfg_i.oc_time)) begin
        ofault_d = 1'b1;
        emer_d   = 1'b1;
        motor_d  = 1'b0;
        status_d = 1'b1;
      end
    end else begin
      over_timing_d = 1'b0;
      over_start_d  = over_start_q;
      if (!emer_q) begin
        ofault_d = 1'b0;
      end
    end

    // Emergency latch.
    if (estop_act) begin
      emer_d   = 1'b1;
      efault_d = 1'b1;
      rehome   = !cls_i.homing;
    end else if (rst_act) begin
      emer_d = 1'b0;
      if (!cfg_i.override_en) begin
        efault_d    = 1'b0;
        clear_other = 1'b1;
      end
    end

    // Relays follow the latch unless held by override.
    if (!cfg_i.override_en) begin
      status_d = emer_d;
      motor_d  = !emer_d;
      mode_d   = cls_i.joystick;
    end

    res_d.relay_motor        = motor_d;
    res_d.relay_status       = status_d;
    res_d.relay_mode         = mode_d;
    res_d.estop_active       = estop_act;
    res_d.select_mode        = sel_lvl_d;
    res_d.reset_active       = rst_act;
    res_d.emergency          = emer_d;
    res_d.fault_estop        = efault_d;
    res_d.overcurrent_fault  = ofault_d;
    res_d.clear_other_faults = clear_other;
    res_d.rehome_request     = rehome;

    if (pop) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Interlock state advances once per popped beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      estop_cnt_q   <= 8'd0;
      linger_q      <= 8'd0;
      sel_cnt_q     <= 8'd0;
      sel_lvl_q     <= 1'b0;
      sel_known_q   <= 1'b0;
      rst_cnt_q     <= 8'd0;
      over_timing_q <= 1'b0;
      over_start_q  <= '0;
      emer_q        <= 1'b0;
      efault_q      <= 1'b0;
      ofault_q      <= 1'b0;
      motor_q       <= 1'b0;
      status_q      <= 1'b0;
      mode_q        <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop) begin
        estop_cnt_q   <= estop_cnt_d;
        linger_q      <= linger_d;
        sel_cnt_q     <= sel_cnt_d;
        sel_lvl_q     <= sel_lvl_d;
        sel_known_q   <= sel_known_d;
        rst_cnt_q     <= rst_cnt_d;
        over_timing_q <= over_timing_d;
        over_start_q  <= over_start_d;
        emer_q        <= emer_d;
        efault_q      <= efault_d;
        ofault_q      <= ofault_d;
        motor_q       <= motor_d;
        status_q      <= status_d;
        mode_q        <= mode_d;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (pop) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

// ===== hw/rtl/estop_safety_interlock_core.sv =====
// Top level of the e-stop safety interlock: config registers and datapath.
//
//   Channel   Direction  Handshake                  Beat contents
//   in        sink       in_valid_i / in_ready_o    raw levels, current, timestamp, modes
//   out       source     out_valid_o / out_ready_i  relays, debounced levels, faults, pulses
//   cfg       sink       cfg_valid_i / cfg_ready_o  register index and write data
//
// An input beat is classified and queued in the same cycle. It is stored in
// the two-entry queue, then popped into the back end, and its result is
// written to the output register; one beat per cycle is sustained while the
// output is taken. The single back-end state update per tick sets that rate.
// Reset clears all interlock state and loads the register defaults; no
// clearing pass is needed. When the output stalls, the output register and
// the two queue entries hold three beats before in_ready_o drops. Config
// writes are always taken.
module estop_safety_interlock_core #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               estop_pressed_raw_i,
  input  logic               select_raw_i,
  input  logic               reset_raw_i,
  input  logic signed [15:0] current_ma_i,
  input  logic [31:0]        now_ms_i,
  input  logic               motor_homing_i,
  input  logic               motor_testing_i,
  input  logic               joystick_mode_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               relay_motor_o,
  output logic               relay_status_o,
  output logic               relay_mode_o,
  output logic               estop_active_o,
  output logic               select_mode_o,
  output logic               reset_active_o,
  output logic               emergency_o,
  output logic               fault_estop_o,
  output logic               overcurrent_fault_o,
  output logic               clear_other_faults_o,
  output logic               rehome_request_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [esi_pkg::CfgDataW-1:0] cfg_data_i
);
  import esi_pkg::*;

  localparam int unsigned QW = ClsW + TIME_WIDTH;

  cfg_t                  cfg_q, cfg_d;
  logic                  push_valid, push_ready;
  cls_t                  front_cls;
  logic [TIME_WIDTH-1:0] front_now;
  logic                  pop_valid, pop_ready;
  logic [QW-1:0]         pop_data;
  cls_t                  back_cls;
  logic [TIME_WIDTH-1:0] back_now;
  res_t                  res;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_OVERRIDE:   cfg_d.override_en = cfg_data_i[0];
        CFG_OC_LIMIT:   cfg_d.oc_limit    = cfg_data_i[14:0];
        CFG_OC_TIME:    cfg_d.oc_time     = cfg_data_i[15:0];
        CFG_IDLE_CNT:   cfg_d.idle_cnt    = cfg_data_i[7:0];
        CFG_RUN_CNT:    cfg_d.run_cnt     = cfg_data_i[7:0];
        CFG_HOMING_CNT: cfg_d.homing_cnt  = cfg_data_i[7:0];
        CFG_LINGER:     cfg_d.linger      = cfg_data_i[7:0];
        CFG_SW_CNT:     cfg_d.sw_cnt      = cfg_data_i[7:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.override_en <= 1'b0;
      cfg_q.oc_limit    <= OcLimitRst;
      cfg_q.oc_time     <= OcTimeRst;
      cfg_q.idle_cnt    <= IdleCntRst;
      cfg_q.run_cnt     <= RunCntRst;
      cfg_q.homing_cnt  <= HomingCntRst;
      cfg_q.linger      <= LingerRst;
      cfg_q.sw_cnt      <= SwCntRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front end.
  esi_front #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_front (
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .estop_pressed_raw_i(estop_pressed_raw_i),
    .select_raw_i       (select_raw_i),
    .reset_raw_i        (reset_raw_i),
    .current_ma_i       (current_ma_i),
    .now_ms_i           (now_ms_i),
    .motor_homing_i     (motor_homing_i),
    .motor_testing_i    (motor_testing_i),
    .joystick_mode_i    (joystick_mode_i),
    .oc_limit_i         (cfg_q.oc_limit),
    .push_valid_o       (push_valid),
    .push_ready_i       (push_ready),
    .cls_o              (front_cls),
    .now_o              (front_now)
  );

  // Queue between the two halves.
  esi_queue #(
    .DW(QW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i ({front_cls, front_now}),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_data_o  (pop_data)
  );

  assign back_cls = cls_t'(pop_data[QW-1:TIME_WIDTH]);
  assign back_now = pop_data[TIME_WIDTH-1:0];

  // Back end.
  esi_back #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .pop_valid_i(pop_valid),
    .pop_ready_o(pop_ready),
    .cls_i      (back_cls),
    .now_i      (back_now),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .res_o      (res)
  );

  assign relay_motor_o        = res.relay_motor;
  assign relay_status_o       = res.relay_status;
  assign relay_mode_o         = res.relay_mode;
  assign estop_active_o       = res.estop_active;
  assign select_mode_o        = res.select_mode;
  assign reset_active_o       = res.reset_active;
  assign emergency_o          = res.emergency;
  assign fault_estop_o        = res.fault_estop;
  assign overcurrent_fault_o  = res.overcurrent_fault;
  assign clear_other_faults_o = res.clear_other_faults;
  assign rehome_request_o     = res.rehome_request;

endmodule

// ===== hw/rtl/esi_checker.sv =====
// Port-level checks on the interlock outputs, bound to the top level.
module esi_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic relay_motor_o,
  input logic relay_status_o,
  input logic estop_active_o,
  input logic reset_active_o,
  input logic emergency_o,
  input logic fault_estop_o,
  input logic clear_other_faults_o,
  input logic rehome_request_o
);

  // A result beat is held until taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result beat dropped before it was taken");

  // Motor power and the red lamp are never on together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(relay_motor_o && relay_status_o))
    else $error("motor relay on while status shows emergency");

  // A debounced e-stop always shows as a latched emergency with its fault.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && estop_active_o) |-> (emergency_o && fault_estop_o))
    else $error("e-stop active without emergency latch and fault");

  // Clearing other faults only comes from a reset that released the emergency and the e-stop fault.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && clear_other_faults_o)
      |-> (reset_active_o && !emergency_o && !fault_estop_o))
    else $error("fault clear pulse without a completed reset");

  // A re-home request only accompanies an active e-stop.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && rehome_request_o) |-> estop_active_o)
    else $error("re-home requested without an e-stop");

endmodule

bind estop_safety_interlock_core esi_checker u_esi_checker (.*);

// ===== dv/interlock_checker.sv =====
// Checker for the e-stop interlock: tracks config writes, predicts each result beat and compares.
module interlock_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic               estop_in_i,
  input  logic               select_raw_i,
  input  logic               reset_raw_i,
  input  logic signed [15:0] current_ma_i,
  input  logic [31:0]        now_ms_i,
  input  logic               homing_i,
  input  logic               testing_i,
  input  logic               joystick_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  esi_pkg::res_t      status_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [esi_pkg::CfgDataW-1:0] cfg_data_i,
  output int                 awaiting_o,
  output int                 mismatches_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import esi_pkg::*;

  // Shadow of the configuration registers.
  cfg_t cfg;

  // Shadow of the interlock state.
  logic [7:0]  estop_cnt;
  logic [7:0]  linger_cnt;
  logic [7:0]  sel_cnt;
  logic [7:0]  rst_cnt;
  logic        sel_level;
  logic        sel_known;
  logic        oc_timing;
  logic [31:0] oc_start;
  logic        emerg;
  logic        flt_estop;
  logic        flt_oc;
  logic        relay_mot;
  logic        relay_stat;
  logic        relay_md;

  // Status beats still owed by the block, oldest first.
  res_t awaited_status[$];
  res_t want;
  int   mismatch_cnt;

  assign mismatches_o = mismatch_cnt;

  task automatic flag_mismatch(string what);
    mismatch_cnt++;
    $display("%0t ns: interlock %s", $time, what);
  endtask

  task automatic check_field(string name, logic got, logic expd);
    if (got !== expd) begin
      flag_mismatch($sformatf("field %s is %b, predicted %b", name, got, expd));
    end
  endtask

  // One refresh tick of the interlock; updates the shadow state.
  function automatic res_t step_interlock(logic estop_in, logic sel_raw, logic rst_raw,
                                          logic signed [15:0] cur, logic [31:0] now,
                                          logic homing, logic testing, logic joystick);
    logic [7:0] thr;
    logic       est_on;
    logic       rst_on;
    logic       over;
    logic       rehome;
    logic       clr;
    int         lim;
    rehome = 1'b0;
    clr = 1'b0;
    lim = int'(cfg.oc_limit);

    // E-stop debounce: the threshold is strict while the motor relay was on recently.
    if (relay_mot) begin
      linger_cnt = cfg.linger;
    end else if (linger_cnt != 8'd0) begin
      linger_cnt = linger_cnt - 8'd1;
    end
    if (linger_cnt != 8'd0) begin
      thr = (homing || testing) ? cfg.homing_cnt : cfg.run_cnt;
    end else begin
      thr = cfg.idle_cnt;
    end
    if (estop_in) begin
      if (estop_cnt < thr) estop_cnt = estop_cnt + 8'd1;
    end else begin
      estop_cnt = 8'd0;
    end
    est_on = estop_cnt >= thr;

    // Mode switch: the first read after reset is taken as is.
    if (!sel_known) begin
      sel_level = sel_raw;
      sel_known = 1'b1;
    end else if (sel_raw != sel_level) begin
      if (sel_cnt < 8'd255) sel_cnt = sel_cnt + 8'd1;
      if (sel_cnt >= cfg.sw_cnt) begin
        sel_level = sel_raw;
        sel_cnt = 8'd0;
      end
    end else begin
      sel_cnt = 8'd0;
    end

    // Reset button debounce.
    if (rst_raw) begin
      if (rst_cnt < cfg.sw_cnt) rst_cnt = rst_cnt + 8'd1;
    end else begin
      rst_cnt = 8'd0;
    end
    rst_on = rst_cnt >= cfg.sw_cnt;

    // Sustained overcurrent; elapsed time wraps with the timestamp.
    over = (int'(cur) > lim) || (int'(cur) < -lim);
    if (!cfg.override_en && over) begin
      if (!oc_timing) begin
        oc_timing = 1'b1;
        oc_start = now;
      end
      if ((now - oc_start) >= {16'd0, cfg.oc_time}) begin
        flt_oc = 1'b1;
        emerg = 1'b1;
        relay_mot = 1'b0;
        relay_stat = 1'b1;
      end
    end else begin
      oc_timing = 1'b0;
      if (!emerg) flt_oc = 1'b0;
    end

    // Emergency latch and its release by the reset button.
    if (est_on) begin
      emerg = 1'b1;
      flt_estop = 1'b1;
      if (!homing) rehome = 1'b1;
    end else if (rst_on) begin
      emerg = 1'b0;
      if (!cfg.override_en) begin
        flt_estop = 1'b0;
        clr = 1'b1;
      end
    end
    if (!cfg.override_en) begin
      relay_stat = emerg;
      relay_mot = !emerg;
      relay_md = joystick;
    end

    return {relay_mot, relay_stat, relay_md, est_on, sel_level, rst_on, emerg,
            flt_estop, flt_oc, clr, rehome};
  endfunction

  // Watch all three channels on each edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg.override_en <= 1'b0;
      cfg.oc_limit    <= OcLimitRst;
      cfg.oc_time     <= OcTimeRst;
      cfg.idle_cnt    <= IdleCntRst;
      cfg.run_cnt     <= RunCntRst;
      cfg.homing_cnt  <= HomingCntRst;
      cfg.linger      <= LingerRst;
      cfg.sw_cnt      <= SwCntRst;
      estop_cnt  <= '0;
      linger_cnt <= '0;
      sel_cnt    <= '0;
      rst_cnt    <= '0;
      sel_level  <= 1'b0;
      sel_known  <= 1'b0;
      oc_timing  <= 1'b0;
      oc_start   <= '0;
      emerg      <= 1'b0;
      flt_estop  <= 1'b0;
      flt_oc     <= 1'b0;
      relay_mot  <= 1'b0;
      relay_stat <= 1'b0;
      relay_md   <= 1'b0;
      awaited_status.delete();
      awaiting_o <= 0;
    end else begin
      // The user must make register writes land only while the block is idle; the block itself does not enforce it.
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_OVERRIDE:   cfg.override_en = cfg_data_i[0];
          CFG_OC_LIMIT:   cfg.oc_limit = cfg_data_i[14:0];
          CFG_OC_TIME:    cfg.oc_time = cfg_data_i[15:0];
          CFG_IDLE_CNT:   cfg.idle_cnt = cfg_data_i[7:0];
          CFG_RUN_CNT:    cfg.run_cnt = cfg_data_i[7:0];
          CFG_HOMING_CNT: cfg.homing_cnt = cfg_data_i[7:0];
          CFG_LINGER:     cfg.linger = cfg_data_i[7:0];
          CFG_SW_CNT:     cfg.sw_cnt = cfg_data_i[7:0];
          default: ;
        endcase
      end

      // Compare a result beat with the oldest prediction.
      if (out_valid_i && out_ready_i) begin
        if (awaited_status.size() == 0) begin
          flag_mismatch("result beat with no tick outstanding");
        end else begin
          want = awaited_status.pop_front();
          check_field("relay_motor", status_i.relay_motor, want.relay_motor);
          check_field("relay_status", status_i.relay_status, want.relay_status);
          check_field("relay_mode", status_i.relay_mode, want.relay_mode);
          check_field("estop_active", status_i.estop_active, want.estop_active);
          check_field("select_mode", status_i.select_mode, want.select_mode);
          check_field("reset_active", status_i.reset_active, want.reset_active);
          check_field("emergency", status_i.emergency, want.emergency);
          check_field("fault_estop", status_i.fault_estop, want.fault_estop);
          check_field("overcurrent_fault", status_i.overcurrent_fault,
                      want.overcurrent_fault);
          check_field("clear_other_faults", status_i.clear_other_faults,
                      want.clear_other_faults);
          check_field("rehome_request", status_i.rehome_request, want.rehome_request);
        end
      end

      // Each accepted tick owes exactly one status beat.
      if (in_valid_i && in_ready_i) begin
        awaited_status.push_back(step_interlock(estop_in_i, select_raw_i, reset_raw_i,
                                                current_ma_i, now_ms_i, homing_i,
                                                testing_i, joystick_i));
      end
      awaiting_o <= awaited_status.size();
    end
  end

endmodule

// ===== dv/tb.sv =====
// Testbench top for the e-stop interlock: clock, reset, tick and config stimulus, verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import esi_pkg::*;

  localparam int StallLimit = 2000;
  localparam int HoldCycles = 60;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // Tick channel.
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               estop_in = 1'b0;
  logic               sel_raw = 1'b0;
  logic               rst_raw = 1'b0;
  logic signed [15:0] cur_ma = '0;
  logic [31:0]        now_ms = '0;
  logic               homing = 1'b0;
  logic               testing = 1'b0;
  logic               joystick = 1'b0;

  // Status channel.
  logic out_valid;
  logic out_ready = 1'b0;
  logic relay_motor, relay_status, relay_mode, estop_active, select_mode, reset_active;
  logic emergency, fault_estop, overcurrent_fault, clear_other_faults, rehome_request;

  // Config channel.
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  cfg_idx_e            cfg_index = CFG_OVERRIDE;
  logic [CfgDataW-1:0] cfg_data = '0;

  int awaiting;
  int mismatches;

  // Stimulus shaping shared between processes.
  logic tx_calm = 1'b0;
  logic rx_calm = 1'b0;
  int   holds_asked = 0;
  int   holds_done = 0;
  int   quiet_cycles = 0;
  int   oc_lim = 10000;

  // Running levels of the random tick generator.
  logic        est_lvl = 1'b0;
  logic        sel_lvl = 1'b0;
  logic        rst_lvl = 1'b0;
  logic        over_on = 1'b0;
  logic        hom_q = 1'b0;
  logic        tst_q = 1'b0;
  logic        joy_q = 1'b0;
  int          est_left = 0;
  int          sel_left = 0;
  int          rst_left = 0;
  int          over_left = 0;
  logic [31:0] now_q = '0;

  estop_safety_interlock_core dut (
    .clk_i                (clk),
    .rst_ni               (rst_n),
    .in_valid_i           (in_valid),
    .in_ready_o           (in_ready),
    .estop_pressed_raw_i  (estop_in),
    .select_raw_i         (sel_raw),
    .reset_raw_i          (rst_raw),
    .current_ma_i         (cur_ma),
    .now_ms_i             (now_ms),
    .motor_homing_i       (homing),
    .motor_testing_i      (testing),
    .joystick_mode_i      (joystick),
    .out_valid_o          (out_valid),
    .out_ready_i          (out_ready),
    .relay_motor_o        (relay_motor),
    .relay_status_o       (relay_status),
    .relay_mode_o         (relay_mode),
    .estop_active_o       (estop_active),
    .select_mode_o        (select_mode),
    .reset_active_o       (reset_active),
    .emergency_o          (emergency),
    .fault_estop_o        (fault_estop),
    .overcurrent_fault_o  (overcurrent_fault),
    .clear_other_faults_o (clear_other_faults),
    .rehome_request_o     (rehome_request),
    .cfg_valid_i          (cfg_valid),
    .cfg_ready_o          (cfg_ready),
    .cfg_index_i          (cfg_index),
    .cfg_data_i           (cfg_data)
  );

  interlock_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .estop_in_i   (estop_in),
    .select_raw_i (sel_raw),
    .reset_raw_i  (rst_raw),
    .current_ma_i (cur_ma),
    .now_ms_i     (now_ms),
    .homing_i     (homing),
    .testing_i    (testing),
    .joystick_i   (joystick),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .status_i     ({relay_motor, relay_status, relay_mode, estop_active, select_mode,
                    reset_active, emergency, fault_estop, overcurrent_fault,
                    clear_other_faults, rehome_request}),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .awaiting_o   (awaiting),
    .mismatches_o (mismatches)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Offer one tick beat after an optional gap and hold it until accepted.
  task automatic offer_tick(logic e, logic s, logic r, logic signed [15:0] c,
                            logic [31:0] n, logic h, logic t, logic j);
    int gap;
    int pick;
    gap = 0;
    if (!tx_calm) begin
      pick = $urandom_range(0, 99);
      if (pick >= 95) gap = $urandom_range(10, 40);
      else if (pick >= 70) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    estop_in  <= e;
    sel_raw   <= s;
    rst_raw   <= r;
    cur_ma    <= c;
    now_ms    <= n;
    homing    <= h;
    testing   <= t;
    joystick  <= j;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop offering ticks and wait until every status beat has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [CfgDataW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Rewrite every register with the block idle.
  task automatic configure(logic ov, logic [14:0] lim, logic [15:0] hold_ms,
                           logic [7:0] idle, logic [7:0] run, logic [7:0] hom,
                           logic [7:0] ling, logic [7:0] sw);
    drain();
    repeat (4) @(posedge clk);
    cfg_write(CFG_OVERRIDE, {15'd0, ov});
    cfg_write(CFG_OC_LIMIT, {1'b0, lim});
    cfg_write(CFG_OC_TIME, hold_ms);
    cfg_write(CFG_IDLE_CNT, {8'd0, idle});
    cfg_write(CFG_RUN_CNT, {8'd0, run});
    cfg_write(CFG_HOMING_CNT, {8'd0, hom});
    cfg_write(CFG_LINGER, {8'd0, ling});
    cfg_write(CFG_SW_CNT, {8'd0, sw});
    cfg_valid <= 1'b0;
    oc_lim = int'(lim);
  endtask

  // Random ticks built from runs of pressed and released levels, bursts of
  // overcurrent and a mostly advancing clock, with some noise mixed in.
  task automatic send_ticks(int count, int press_max, int step_max);
    logic               e;
    logic               s;
    logic               r;
    logic signed [15:0] c;
    int                 mag;
    for (int k = 0; k < count; k++) begin
      if (est_left == 0) begin
        est_lvl = !est_lvl;
        if (!est_lvl) est_left = $urandom_range(1, 30);
        else if ($urandom_range(0, 7) == 0) est_left = $urandom_range(1, 260);
        else est_left = $urandom_range(1, press_max);
      end
      est_left--;
      if (sel_left == 0) begin
        sel_lvl = !sel_lvl;
        sel_left = $urandom_range(1, 8);
      end
      sel_left--;
      if (rst_left == 0) begin
        rst_lvl = !rst_lvl;
        rst_left = rst_lvl ? $urandom_range(1, 6) : $urandom_range(4, 40);
      end
      rst_left--;
      if (over_left == 0) begin
        over_on = !over_on;
        over_left = over_on ? $urandom_range(1, 40) : $urandom_range(1, 30);
      end
      over_left--;
      if ($urandom_range(0, 15) == 0) hom_q = !hom_q;
      if ($urandom_range(0, 15) == 0) tst_q = !tst_q;
      if ($urandom_range(0, 15) == 0) joy_q = !joy_q;
      if ($urandom_range(0, 39) == 0) now_q = $urandom;
      else now_q = now_q + $urandom_range(0, step_max);

      if (over_on) mag = $urandom_range(oc_lim + 1, 32768);
      else mag = $urandom_range(0, oc_lim);
      if ($urandom_range(0, 1) == 1) mag = -mag;
      if (mag > 32767) mag = 32767;
      c = 16'(mag);

      e = est_lvl;
      s = sel_lvl;
      r = rst_lvl;
      if ($urandom_range(0, 11) == 0) begin
        e = 1'($urandom_range(0, 1));
        s = 1'($urandom_range(0, 1));
        r = 1'($urandom_range(0, 1));
        c = 16'($urandom);
      end
      offer_tick(e, s, r, c, now_q, hom_q, tst_q, joy_q);
    end
  endtask

  // Receiver: random ready pattern, long hold-offs on request, none while calm.
  initial begin
    int len;
    int pick;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (holds_asked != holds_done) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        holds_done++;
      end else if (rx_calm) begin
        out_ready <= 1'b1;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
          out_ready <= 1'b1;
          len = $urandom_range(1, 12);
        end else if (pick < 92) begin
          out_ready <= 1'b0;
          len = $urandom_range(1, 3);
        end else begin
          out_ready <= 1'b0;
          len = $urandom_range(8, 30);
        end
        repeat (len - 1) @(posedge clk);
      end
    end
  end

  // Watchdog: too long without any beat on any channel ends the run.
  initial begin
    while (quiet_cycles < StallLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("TB_ERROR");
    $finish;
  end

  // Main sequence: directed ticks, then random phases over several settings.
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: short thresholds so each corner shows up within a few ticks.
    configure(1'b0, 15'd100, 16'd3, 8'd2, 8'd3, 8'd4, 8'd2, 8'd2);
    offer_tick(1'b0, 1'b1, 1'b0, 16'sd0, 32'd0, 1'b0, 1'b0, 1'b0);
    offer_tick(1'b0, 1'b1, 1'b0, 16'sh7FFF, 32'hFFFF_FFFE, 1'b0, 1'b0, 1'b1);
    offer_tick(1'b0, 1'b1, 1'b0, 16'sh8000, 32'h0000_0001, 1'b0, 1'b0, 1'b1);
    offer_tick(1'b0, 1'b1, 1'b0, 16'sd0, 32'd2, 1'b0, 1'b0, 1'b1);
    offer_tick(1'b0, 1'b1, 1'b1, 16'sd0, 32'd3, 1'b0, 1'b0, 1'b1);
    offer_tick(1'b0, 1'b1, 1'b1, 16'sd0, 32'd4, 1'b0, 1'b0, 1'b1);
    offer_tick(1'b0, 1'b1, 1'b0, 16'sd0, 32'd5, 1'b0, 1'b0, 1'b1);
    // E-stop held through the homing threshold: no re-home while homing.
    for (int k = 0; k < 4; k++) begin
      offer_tick(1'b1, 1'b1, 1'b0, 16'sd0, 32'd6 + k, 1'b1, 1'b0, 1'b0);
    end
    offer_tick(1'b1, 1'b0, 1'b0, 16'sd0, 32'd10, 1'b0, 1'b1, 1'b0);
    offer_tick(1'b0, 1'b0, 1'b1, 16'sd0, 32'd11, 1'b0, 1'b0, 1'b0);
    offer_tick(1'b0, 1'b0, 1'b1, 16'sd0, 32'd12, 1'b0, 1'b0, 1'b0);
    // Overcurrent timed from a zero timestamp, on both signs and at the limit.
    offer_tick(1'b0, 1'b0, 1'b0, -16'sd101, 32'd0, 1'b0, 1'b0, 1'b0);
    offer_tick(1'b0, 1'b0, 1'b0, 16'sd101, 32'd2, 1'b0, 1'b0, 1'b0);
    offer_tick(1'b0, 1'b0, 1'b0, 16'sd100, 32'd3, 1'b0, 1'b0, 1'b0);
    offer_tick(1'b0, 1'b0, 1'b0, -16'sd100, 32'd4, 1'b0, 1'b0, 1'b0);
    // Override: the e-stop still latches, the reset keeps the fault.
    configure(1'b1, 15'd100, 16'd3, 8'd2, 8'd3, 8'd4, 8'd2, 8'd2);
    offer_tick(1'b1, 1'b0, 1'b0, 16'sd30000, 32'd5, 1'b0, 1'b0, 1'b1);
    offer_tick(1'b1, 1'b0, 1'b0, 16'sd30000, 32'd100, 1'b0, 1'b0, 1'b1);
    offer_tick(1'b1, 1'b0, 1'b0, -16'sd30000, 32'd200, 1'b0, 1'b0, 1'b0);
    offer_tick(1'b0, 1'b0, 1'b1, 16'sd0, 32'd201, 1'b0, 1'b0, 1'b0);
    offer_tick(1'b0, 1'b0, 1'b1, 16'sd0, 32'd202, 1'b0, 1'b0, 1'b0);

    // Random phases.
    configure(1'b0, OcLimitRst, OcTimeRst, IdleCntRst, RunCntRst, HomingCntRst,
              LingerRst, SwCntRst);
    send_ticks(100, 90, 20);
    configure(1'b0, 15'd500, 16'd10, 8'd3, 8'd6, 8'd9, 8'd4, 8'd3);
    send_ticks(100, 12, 4);
    // Zero thresholds and no strict window.
    configure(1'b0, 15'd0, 16'd0, 8'd0, 8'd1, 8'd255, 8'd0, 8'd0);
    send_ticks(40, 4, 3);
    configure(1'b1, 15'd32767, 16'd65535, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    send_ticks(50, 40, 1000);
    configure(1'b1, 15'd200, 16'd5, 8'd2, 8'd3, 8'd4, 8'd3, 8'd2);
    send_ticks(60, 6, 3);
    configure(1'b0, 15'd1000, 16'd30, 8'd4, 8'd8, 8'd12, 8'd10, 8'd2);
    send_ticks(40, 14, 8);
    // Receiver holds off while ticks keep coming, so the input backs up.
    holds_asked++;
    tx_calm = 1'b1;
    send_ticks(40, 14, 8);
    tx_calm = 1'b0;
    drain();
    // A stretch with no idling on either side.
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    send_ticks(30, 14, 8);
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    send_ticks(40, 14, 8);

    drain();
    repeat (5) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
